FILE: src/pcxrle_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pcxrle_pkg;

  // Stream widths and PCX run-length constants
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned LEN_W       = 7;
  localparam int unsigned SLOT_N      = 4;
  localparam int unsigned SLOT_W      = 2;
  localparam int unsigned MAX_RUN_DEF = 64;

  localparam logic [BYTE_W-1:0] LIT_MAX  = 8'd191;
  localparam logic [BYTE_W-1:0] CNT_BASE = 8'd192;

  // Codec mode register codes
  localparam logic MODE_ENC = 1'b0;
  localparam logic MODE_DEC = 1'b1;

  // Slot holding the repeated byte
  localparam logic [SLOT_W-1:0] SLOT_REP = 2'd3;

  typedef enum logic {
    CTL_IDLE,
    CTL_EMIT
  } ctl_state_e;

  typedef struct packed {
    logic load;
    logic step;
  } ctl_cmd_t;

  typedef struct packed {
    logic has_results;
    logic out_free;
    logic step_final;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: src/pcxrle_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module pcxrle_ctrl
  import pcxrle_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire dp_status_t status_i,
  output ctl_cmd_t        cmd_o
);

  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CTL_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      CTL_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (status_i.has_results) begin
            state_d = CTL_EMIT;
          end
        end
      end
      CTL_EMIT: begin
        // advance one result whenever the output register can take it
        if (status_i.out_free) begin
          cmd_o.step = 1'b1;
          if (status_i.step_final) begin
            state_d = CTL_IDLE;
          end
        end
      end
      default: begin
        state_d = CTL_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: src/pcxrle_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module pcxrle_dp
  import pcxrle_pkg::*;
#(
  parameter int unsigned MAX_RUN = MAX_RUN_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_wdata_i,
  input  wire logic [BYTE_W-1:0] data_byte_i,
  input  wire logic              last_of_block_i,
  input  wire ctl_cmd_t          cmd_i,
  output dp_status_t             status_o,
  input  wire logic              out_ready_i,
  output logic                   out_valid_o,
  output logic [BYTE_W-1:0]      out_byte_o,
  output logic                   run_last_o,
  output logic                   block_end_o,
  output logic                   truncated_error_o
);

  function automatic logic [BYTE_W-1:0] count_byte(input logic [LEN_W-1:0] len);
    count_byte = BYTE_W'({1'b0, LIT_MAX} + {2'b00, len});
  endfunction

  // Codec state
  logic              mode_q;
  logic [BYTE_W-1:0] held_q, held_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic              hold_q, hold_d;

  // Result sequence of the current transaction
  logic [BYTE_W-1:0] slot_q [SLOT_N];
  logic [BYTE_W-1:0] slot_d [SLOT_N];
  logic [SLOT_N-1:0] rem_q, mask_d, rem_next;
  logic [LEN_W-1:0]  rep_q, rep_d;
  logic              last_q, trunc_q, trunc_d;

  logic              extend;
  logic [SLOT_W-1:0] sel;
  logic              sel_done;
  logic              step_final;

  // Output register
  logic              out_valid_q;
  logic [BYTE_W-1:0] out_byte_q;
  logic              run_last_q, block_end_q, trunc_err_q;

  always_comb begin
    for (int i = 0; i < SLOT_N; i++) begin
      slot_d[i] = '0;
    end
    mask_d  = '0;
    rep_d   = LEN_W'(1);
    trunc_d = 1'b0;
    held_d  = held_q;
    len_d   = len_q;
    hold_d  = hold_q;
    extend  = hold_q && (data_byte_i == held_q) && (len_q < LEN_W'(MAX_RUN));
    if (mode_q == MODE_ENC) begin
      if (extend) begin
        len_d = len_q + LEN_W'(1);
      end else begin
        if (hold_q) begin
          mask_d[0] = (held_q > LIT_MAX) || (len_q > LEN_W'(1));
          slot_d[0] = count_byte(len_q);
          mask_d[1] = 1'b1;
          slot_d[1] = held_q;
        end
        held_d = data_byte_i;
        len_d  = LEN_W'(1);
        hold_d = 1'b1;
      end
      if (last_of_block_i) begin
        mask_d[2] = (held_d > LIT_MAX) || (len_d > LEN_W'(1));
        slot_d[2] = count_byte(len_d);
        mask_d[3] = 1'b1;
        slot_d[3] = held_d;
        held_d    = '0;
        len_d     = '0;
        hold_d    = 1'b0;
      end
    end else begin
      if (hold_q) begin
        mask_d[3] = 1'b1;
        slot_d[3] = data_byte_i;
        rep_d     = len_q;
        len_d     = '0;
        hold_d    = 1'b0;
      end else if (data_byte_i > LIT_MAX) begin
        if (last_of_block_i) begin
          mask_d[3] = 1'b1;
          trunc_d   = 1'b1;
        end else begin
          hold_d = 1'b1;
          len_d  = LEN_W'(data_byte_i - LIT_MAX);
        end
      end else begin
        mask_d[3] = 1'b1;
        slot_d[3] = data_byte_i;
      end
    end
  end

  // Lowest pending slot goes out first
  always_comb begin
    priority if (rem_q[0]) sel = 2'd0;
    else if (rem_q[1])     sel = 2'd1;
    else if (rem_q[2])     sel = 2'd2;
    else                   sel = SLOT_REP;
  end

  always_comb begin
    sel_done      = (sel != SLOT_REP) || (rep_q <= LEN_W'(1));
    rem_next      = rem_q;
    rem_next[sel] = rem_q[sel] & ~sel_done;
    step_final    = (rem_next == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_ENC;
      held_q <= '0;
      len_q  <= '0;
      hold_q <= 1'b0;
      rem_q  <= '0;
      rep_q  <= '0;
    end else if (cfg_we_i) begin
      // mode change drops any half-done run or count
      mode_q <= cfg_wdata_i;
      held_q <= '0;
      len_q  <= '0;
      hold_q <= 1'b0;
    end else if (cmd_i.load) begin
      held_q <= held_d;
      len_q  <= len_d;
      hold_q <= hold_d;
      rem_q  <= mask_d;
      rep_q  <= rep_d;
    end else if (cmd_i.step) begin
      rem_q <= rem_next;
      if (!sel_done) begin
        rep_q <= rep_q - LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int i = 0; i < SLOT_N; i++) begin
        slot_q[i] <= slot_d[i];
      end
      last_q  <= last_of_block_i;
      trunc_q <= trunc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      out_byte_q  <= slot_q[sel];
      run_last_q  <= step_final;
      block_end_q <= step_final & last_q;
      trunc_err_q <= step_final & trunc_q;
    end
  end

  always_comb begin
    status_o.has_results = |mask_d;
    status_o.out_free    = !out_valid_q || out_ready_i;
    status_o.step_final  = step_final;
  end

  assign out_valid_o       = out_valid_q;
  assign out_byte_o        = out_byte_q;
  assign run_last_o        = run_last_q;
  assign block_end_o       = block_end_q;
  assign truncated_error_o = trunc_err_q;

  a_trunc_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && trunc_err_q |-> run_last_q && block_end_q && (out_byte_q == '0))
    else $error("truncated result is not a lone zero at block end");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && block_end_q |-> run_last_q)
    else $error("block end on a result that is not the last of its transaction");

  a_rep_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q[SLOT_REP] |-> (rep_q != '0))
    else $error("repeat slot pending with zero count");

endmodule

`default_nettype wire

FILE: src/pcx_byte_run_length_codec_top.sv
// A transaction is taken when in_valid_i is high while idle, then its results are stepped
// into the output register one result per cycle while the sink takes them.
// A transaction yields up to 64 results in decode and up to 4 in encode; no new byte is
// taken until its last result is stepped out. The result sequencer is the limit.
// Reset: asynchronous, active low; mode returns to encode and run state is cleared.
`timescale 1ns / 1ps
`default_nettype none

module pcx_byte_run_length_codec_top
  import pcxrle_pkg::*;
#(
  parameter int unsigned MAX_RUN = MAX_RUN_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // configuration: codec mode, 0 encode, 1 decode
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_wdata_i,
  // input byte stream
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [BYTE_W-1:0] data_byte_i,
  input  wire logic              last_of_block_i,
  // output byte stream
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [BYTE_W-1:0]      out_byte_o,
  output logic                   run_last_o,
  output logic                   block_end_o,
  output logic                   truncated_error_o
);

  ctl_cmd_t   cmd;
  dp_status_t status;

  // Controller: take a transaction, then step its results out one at a time
  pcxrle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath: run/count state, result slots with repeat counter, output register
  pcxrle_dp #(
    .MAX_RUN (MAX_RUN)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .data_byte_i       (data_byte_i),
    .last_of_block_i   (last_of_block_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .out_byte_o        (out_byte_o),
    .run_last_o        (run_last_o),
    .block_end_o       (block_end_o),
    .truncated_error_o (truncated_error_o)
  );

endmodule

`default_nettype wire
